/* rtl/cdtc_pkg.sv */
// Shared types and constants for the colour text display block.
// No dependencies; imported by every module of the block except cdtc_div.
package cdtc_pkg;

  // Default number of text cells, and the widest row index any legal cell count needs.
  localparam int CDTC_TEXT_CELLS = 256;
  localparam int CDTC_ROW_MAX_W  = 10;

  localparam logic [7:0] CDTC_GLYPH_COLUMNS_RST = 8'd16;
  localparam logic [7:0] CDTC_CHAR_RST          = 8'h20;
  localparam logic [7:0] CDTC_COLOUR_RST        = 8'h0F;

  localparam int CDTC_QDEPTH = 2;

  // Input mode codes.
  localparam logic [2:0] MODE_WORD_RD  = 3'd0;
  localparam logic [2:0] MODE_WORD_WR  = 3'd1;
  localparam logic [2:0] MODE_BYTE_RD  = 3'd2;
  localparam logic [2:0] MODE_BYTE_WR  = 3'd3;
  localparam logic [2:0] MODE_RENDER   = 3'd4;
  localparam logic [2:0] MODE_FRAME    = 3'd5;

  typedef enum logic [2:0] {
    CMD_ZERO,
    CMD_RD_MEM,
    CMD_WR_MEM,
    CMD_RD_VEC,
    CMD_WR_VEC,
    CMD_RENDER,
    CMD_FRAME
  } cmd_op_t;

  // Decoded command: one per accepted transfer.
  typedef struct packed {
    cmd_op_t                   op;
    logic                      colour;   // 1: colour store, 0: char store
    logic [CDTC_ROW_MAX_W-1:0] row;
    logic [3:0]                be;       // byte lanes touched
    logic [1:0]                lane;     // lane for byte reads and render
    logic                      is_byte;
    logic [31:0]               data;     // byte writes carry the byte in every lane
    logic                      raise;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [7:0]  char_code;
    logic [7:0]  glyph_column;
    logic [7:0]  glyph_row;
    logic [3:0]  fg_index;
    logic [3:0]  bg_index;
    logic        interrupt_request;
    logic [31:0] interrupt_vector;
  } res_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MEM,
    BK_DIV
  } back_state_t;

endpackage

/* rtl/cdtc_front.sv */
// Front end: accepts a transfer and decodes mode and address into a command.
// Depends on cdtc_pkg.
module cdtc_front import cdtc_pkg::*; #(
  parameter int TEXT_CELLS = CDTC_TEXT_CELLS
) (
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic [7:0]  cell_index,
  input  logic        raise_interrupt,
  input  logic        q_full,
  input  logic        clearing,
  output logic        push,
  output cmd_t        cmd
);

  localparam int COLOUR_BASE = ((TEXT_CELLS + 3) / 4) * 4;
  localparam int VECTOR_BASE = 2 * COLOUR_BASE;
  localparam int WINDOW_SIZE = VECTOR_BASE + 4;

  localparam logic [31:0] COLOUR_BASE_W = 32'(COLOUR_BASE);
  localparam logic [31:0] VECTOR_BASE_W = 32'(VECTOR_BASE);
  localparam logic [31:0] WINDOW_SIZE_W = 32'(WINDOW_SIZE);
  localparam logic [31:0] CELLS_W       = 32'(TEXT_CELLS);

  logic        in_colour;
  logic [31:0] off;
  logic [3:0]  word_be;
  logic [3:0]  byte_be;

  assign busy = q_full | clearing;
  assign push = start & ~busy;

  assign in_colour = (address >= COLOUR_BASE_W);
  assign off       = in_colour ? (address - COLOUR_BASE_W) : address;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      word_be[k] = ((off + 32'(k)) < CELLS_W);
    end
    byte_be = 4'b0001 << address[1:0];
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = CMD_ZERO;
    cmd.colour  = in_colour;
    cmd.row     = off[CDTC_ROW_MAX_W+1:2];
    cmd.lane    = address[1:0];
    cmd.data    = write_data;
    cmd.raise   = raise_interrupt;
    case (mode)
      MODE_WORD_RD, MODE_WORD_WR: begin
        cmd.be = word_be;
        if (address == VECTOR_BASE_W) begin
          cmd.op = (mode == MODE_WORD_WR) ? CMD_WR_VEC : CMD_RD_VEC;
          cmd.be = 4'hF;
        end else if (address < VECTOR_BASE_W && address[1:0] == 2'b00) begin
          cmd.op = (mode == MODE_WORD_WR) ? CMD_WR_MEM : CMD_RD_MEM;
        end
      end
      MODE_BYTE_RD, MODE_BYTE_WR: begin
        cmd.is_byte = 1'b1;
        cmd.be      = byte_be;
        cmd.data    = {4{write_data[7:0]}};
        if (address >= WINDOW_SIZE_W) begin
          cmd.op = CMD_ZERO;
        end else if (address >= VECTOR_BASE_W) begin
          cmd.op = (mode == MODE_BYTE_WR) ? CMD_WR_VEC : CMD_RD_VEC;
        end else if (off < CELLS_W) begin
          cmd.op = (mode == MODE_BYTE_WR) ? CMD_WR_MEM : CMD_RD_MEM;
        end
      end
      MODE_RENDER: begin
        cmd.row  = CDTC_ROW_MAX_W'(cell_index[7:2]);
        cmd.lane = cell_index[1:0];
        if (32'(cell_index) < CELLS_W) begin
          cmd.op = CMD_RENDER;
        end
      end
      MODE_FRAME: begin
        cmd.op = CMD_FRAME;
      end
      default: begin
        cmd.op = CMD_ZERO;
      end
    endcase
  end

endmodule

/* rtl/cdtc_queue.sv */
// Short command queue between front end and back end.
// Depends on cdtc_pkg (cmd_t, CDTC_QDEPTH).
module cdtc_queue import cdtc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (CDTC_QDEPTH > 1) ? $clog2(CDTC_QDEPTH) : 1;
  localparam int CNT_W = $clog2(CDTC_QDEPTH + 1);

  cmd_t             entry_r [CDTC_QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(CDTC_QDEPTH));
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CDTC_QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CDTC_QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* rtl/cdtc_div.sv */
// 8-bit restoring divider, one quotient bit per cycle.
// Does not import cdtc_pkg; no types from it are used.
module cdtc_div (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient,
  output logic [7:0] remainder
);

  logic       active_r, active_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       done_r, done_nxt;
  logic [7:0] quo_r, quo_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] dsr_r, dsr_nxt;
  logic [8:0] trial;

  assign trial     = {rem_r, quo_r[7]};
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dsr_nxt    = dsr_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      quo_nxt    = dividend;
      rem_nxt    = '0;
      dsr_nxt    = divisor;
    end else if (active_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 8'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[6:0], 1'b1};
      end else begin
        rem_nxt = trial[7:0];
        quo_nxt = {quo_r[6:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 3'd7) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

/* rtl/cdtc_back.sv */
// Back end: char/colour stores, interrupt vector, render divide and result register.
// Depends on cdtc_pkg and cdtc_div.
module cdtc_back import cdtc_pkg::*; #(
  parameter int TEXT_CELLS = CDTC_TEXT_CELLS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       pop,
  input  logic [7:0] glyph_columns,
  output logic       clearing,
  output logic       res_valid,
  output res_t       res
);

  localparam int ROWS  = (TEXT_CELLS + 3) / 4;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  back_state_t state_r, state_nxt;

  logic [3:0][7:0] char_mem [ROWS];
  logic [3:0][7:0] col_mem  [ROWS];
  logic [3:0][7:0] char_q_r;
  logic [3:0][7:0] col_q_r;

  logic [ROW_W-1:0] clr_row_r, clr_row_nxt;
  logic [ROW_W-1:0] wr_row;
  logic [3:0]       char_we, col_we, vec_we;
  logic [31:0]      char_wdata, col_wdata;

  logic [3:0][7:0] vec_r;
  cmd_t            cur_r;
  logic [7:0]      sel_char_r, sel_col_r;
  logic            load_sel;

  logic       out_valid_r, emit;
  res_t       res_r, res_nxt;

  logic       div_start, div_done;
  logic [7:0] div_quo, div_rem;
  logic [7:0] mem_char, mem_col;

  cdtc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (mem_char),
    .divisor   (glyph_columns),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign clearing  = (state_r == BK_CLEAR);
  assign res_valid = out_valid_r;
  assign res       = res_r;
  assign mem_char  = char_q_r[cur_r.lane];
  assign mem_col   = col_q_r[cur_r.lane];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (clr_row_r == ROW_W'(ROWS - 1)) state_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty && (head.op == CMD_RD_MEM || head.op == CMD_RENDER)) begin
          state_nxt = BK_MEM;
        end
      end
      BK_MEM: begin
        if (cur_r.op == CMD_RENDER && glyph_columns != 8'd0) state_nxt = BK_DIV;
        else                                                state_nxt = BK_IDLE;
      end
      BK_DIV: begin
        if (div_done) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    pop         = 1'b0;
    char_we     = '0;
    col_we      = '0;
    vec_we      = '0;
    wr_row      = head.row[ROW_W-1:0];
    char_wdata  = head.data;
    col_wdata   = head.data;
    clr_row_nxt = clr_row_r;
    div_start   = 1'b0;
    load_sel    = 1'b0;
    emit        = 1'b0;
    res_nxt     = '0;
    case (state_r)
      BK_CLEAR: begin
        wr_row      = clr_row_r;
        char_we     = 4'hF;
        col_we      = 4'hF;
        char_wdata  = {4{CDTC_CHAR_RST}};
        col_wdata   = {4{CDTC_COLOUR_RST}};
        clr_row_nxt = clr_row_r + 1'b1;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          pop  = 1'b1;
          emit = 1'b1;
          case (head.op)
            CMD_WR_MEM: begin
              if (head.colour) col_we  = head.be;
              else             char_we = head.be;
            end
            CMD_WR_VEC: vec_we = head.be;
            CMD_RD_VEC: begin
              if (head.is_byte) res_nxt.read_data = 32'(vec_r[head.lane]);
              else              res_nxt.read_data = vec_r;
            end
            CMD_FRAME: begin
              if (head.raise && vec_r != '0) begin
                res_nxt.interrupt_request = 1'b1;
                res_nxt.interrupt_vector  = vec_r;
              end
            end
            CMD_RD_MEM, CMD_RENDER: emit = 1'b0;
            default: ;
          endcase
        end
      end
      BK_MEM: begin
        if (cur_r.op == CMD_RENDER) begin
          load_sel = 1'b1;
          if (glyph_columns == 8'd0) begin
            emit                 = 1'b1;
            res_nxt.char_code    = mem_char;
            res_nxt.glyph_column = mem_char;
            res_nxt.fg_index     = mem_col[3:0];
            res_nxt.bg_index     = mem_col[7:4];
          end else begin
            div_start = 1'b1;
          end
        end else begin
          emit = 1'b1;
          if (cur_r.is_byte) begin
            res_nxt.read_data = cur_r.colour ? 32'(mem_col) : 32'(mem_char);
          end else begin
            for (int k = 0; k < 4; k++) begin
              res_nxt.read_data[8*k +: 8] = cur_r.be[k] ?
                  (cur_r.colour ? col_q_r[k] : char_q_r[k]) : 8'h00;
            end
          end
        end
      end
      BK_DIV: begin
        if (div_done) begin
          emit                 = 1'b1;
          res_nxt.char_code    = sel_char_r;
          res_nxt.glyph_column = div_rem;
          res_nxt.glyph_row    = div_quo;
          res_nxt.fg_index     = sel_col_r[3:0];
          res_nxt.bg_index     = sel_col_r[7:4];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_row_r   <= '0;
      vec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      out_valid_r <= emit;
      for (int k = 0; k < 4; k++) begin
        if (vec_we[k]) vec_r[k] <= head.data[8*k +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (pop) cur_r <= head;
    if (load_sel) begin
      sel_char_r <= mem_char;
      sel_col_r  <= mem_col;
    end
  end

  // Row-wide stores with per-lane write enables, registered read.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (char_we[k]) char_mem[wr_row][k] <= char_wdata[8*k +: 8];
      if (col_we[k])  col_mem[wr_row][k]  <= col_wdata[8*k +: 8];
    end
    char_q_r <= char_mem[head.row[ROW_W-1:0]];
    col_q_r  <= col_mem[head.row[ROW_W-1:0]];
  end

endmodule

/* rtl/char_display_text_colour_memory_top.sv */
// Top level of the colour text display: front decode, command queue, back end.
// Depends on cdtc_pkg, cdtc_front, cdtc_queue, cdtc_back, cdtc_div.
//
// Usage:
//   Input channel: drive in_* and raise start; the transfer happens at a rising
//   edge where start is high and busy is low. Every transfer yields exactly one
//   result, in order.
//   Result channel: out_valid is high for one cycle with the out_* fields; the
//   receiver must take it then, there is no back-pressure.
//   Config: cfg_write_en with cfg_write_data sets the glyph-columns divisor
//   (reset 16). Write it only when no transfer is outstanding.
//   Result path: every result leaves through the queue and the result register;
//   store reads also pass the registered store read, and a cell render also
//   runs the 8-step divider, unless the divisor is zero.
//   Throughput: one transfer per cycle for non-read work while busy is low;
//   store reads and renders hold the back end longer, through the registered
//   store read and the bit-serial divider. A 2-entry queue lets the front keep
//   taking transfers while the back end is occupied; busy rises when it fills.
//   Reset: rst_n is synchronous. Afterwards a clearing pass fills the stores
//   with space characters and colour 0x0F; busy stays high until it is done.
module char_display_text_colour_memory_top import cdtc_pkg::*; #(
  parameter int TEXT_CELLS = CDTC_TEXT_CELLS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic [7:0]  in_cell_index,
  input  logic        in_raise_interrupt,
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic [7:0]  out_char_code,
  output logic [7:0]  out_glyph_column,
  output logic [7:0]  out_glyph_row,
  output logic [3:0]  out_fg_index,
  output logic [3:0]  out_bg_index,
  output logic        out_interrupt_request,
  output logic [31:0] out_interrupt_vector
);

  logic [7:0] glyph_columns_r;
  logic       push, pop, q_empty, q_full, clearing;
  cmd_t       push_cmd, head;
  res_t       res;

  // Glyph-columns register; the user must keep it written only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_columns_r <= CDTC_GLYPH_COLUMNS_RST;
    end else if (cfg_write_en) begin
      glyph_columns_r <= cfg_write_data;
    end
  end

  // Decode: window checks, alignment, lane masks.
  cdtc_front #(.TEXT_CELLS(TEXT_CELLS)) u_front (
    .start           (start),
    .busy            (busy),
    .mode            (in_mode),
    .address         (in_address),
    .write_data      (in_write_data),
    .cell_index      (in_cell_index),
    .raise_interrupt (in_raise_interrupt),
    .q_full          (q_full),
    .clearing        (clearing),
    .push            (push),
    .cmd             (push_cmd)
  );

  // Decouples decode from execution.
  cdtc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Executes commands in order and registers each result.
  cdtc_back #(.TEXT_CELLS(TEXT_CELLS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .glyph_columns (glyph_columns_r),
    .clearing      (clearing),
    .res_valid     (out_valid),
    .res           (res)
  );

  assign out_read_data         = res.read_data;
  assign out_char_code         = res.char_code;
  assign out_glyph_column      = res.glyph_column;
  assign out_glyph_row         = res.glyph_row;
  assign out_fg_index          = res.fg_index;
  assign out_bg_index          = res.bg_index;
  assign out_interrupt_request = res.interrupt_request;
  assign out_interrupt_vector  = res.interrupt_vector;

endmodule
